// ----- rtl/core/clsa_pkg.sv -----
package clsa_pkg;

  localparam int CAL_REGS = 3;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd3;
  localparam logic [63:0] CAL_RESET = 64'd2748779074560;
  localparam logic [4:0] WINDOW_RESET = 5'd10;
  localparam logic signed [31:0] SPAN_ERR_VALUE = -32'sd65470464;
  localparam int ZERO_BAND = 656;
  localparam int CURRENT_DIV = 183;

  typedef struct packed {
    logic        valid_ch;
    logic [2:0]  channel;
    logic [12:0] raw;
    logic [63:0] cal;
  } clsa_req_t;

endpackage

// ----- rtl/core/clsa_ram.sv -----
module clsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/clsa_front.sv -----
module clsa_front import clsa_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_channel,
  input  logic [15:0] in_shunt_word,
  input  logic [63:0] cal0,
  input  logic [63:0] cal1,
  input  logic [63:0] cal2,
  output logic        q_valid,
  output clsa_req_t   q_req,
  input  logic        q_take
);

  clsa_req_t buf_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  clsa_req_t  req;
  logic       acc;

  always_comb begin
    req.channel = {1'b0, in_channel};
    req.raw = in_shunt_word[15:3];
    req.valid_ch = (int'(in_channel) < CHANNELS) && (int'(in_channel) < CAL_REGS);
    case (in_channel)
      2'd0: req.cal = cal0;
      2'd1: req.cal = cal1;
      2'd2: req.cal = cal2;
      default: req.cal = '0;
    endcase
  end

  assign in_full = (cnt_r == 2'd2);
  assign acc = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (acc) begin
      buf_r[wr_r] <= req;
    end
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (acc) begin
        wr_r <= !wr_r;
      end
      if (q_take) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + {1'b0, acc} - {1'b0, q_take};
    end
  end

endmodule

// ----- rtl/core/clsa_back.sv -----
module clsa_back import clsa_pkg::*; #(
  parameter int MAX_WINDOW = 16,
  parameter int CHANNELS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [4:0]         window_len,
  input  logic               q_valid,
  input  clsa_req_t          q_req,
  output logic               q_take,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [12:0]        out_shunt_count,
  output logic signed [31:0] out_magnitude,
  output logic signed [31:0] out_average,
  output logic               out_span_error
);

  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * MAX_WINDOW;
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MUL1, S_MUL2, S_ABS, S_DIV, S_FIX, S_WR, S_SUM, S_SUMW, S_AVG, S_OUT
  } state_t;

  state_t state_r;
  clsa_req_t req_r;
  logic [AW-1:0] clr_r;
  logic signed [31:0] dif_r;
  logic signed [31:0] mdif_r;
  logic signed [63:0] num_r;
  logic [63:0] nabs_r, quo_r, rem_r;
  logic [31:0] den_r;
  logic neg_r;
  logic [6:0] it_r;
  logic signed [63:0] x_r;
  logic err_r;
  logic [WW-1:0] len_r;
  logic [PW-1:0] pos_r [CHANNELS];
  logic [PW-1:0] wpos_r;
  logic [WW-1:0] idx_r;
  logic signed [39:0] sum_r;
  logic [12:0] o_raw_r;
  logic signed [31:0] o_mag_r, o_avg_r;
  logic o_err_r, o_full_r;

  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [31:0] ram_wd, ram_rd;

  clsa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra), .rdata(ram_rd)
  );

  logic [CW-1:0] ch;
  logic [WW-1:0] eff_len;
  logic [7:0] imin, imax;
  logic signed [15:0] mmin, mmax, offs;
  logic [15:0] dspan;
  logic [64:0] trial;
  logic signed [63:0] xadj;
  logic signed [63:0] xsat;
  logic [39:0] sabs;

  assign ch = q_req.channel[CW-1:0];
  assign imin = req_r.cal[7:0];
  assign imax = req_r.cal[15:8];
  assign mmin = req_r.cal[31:16];
  assign mmax = req_r.cal[47:32];
  assign offs = req_r.cal[63:48];
  assign dspan = {8'd0, imax} - {8'd0, imin};

  always_comb begin
    if (window_len == 5'd0) eff_len = WW'(1);
    else if (int'(window_len) > MAX_WINDOW) eff_len = WW'(MAX_WINDOW);
    else eff_len = WW'(window_len);
  end

  assign trial = {rem_r, nabs_r[63]} - {33'd0, den_r};
  assign xadj = (neg_r ? -$signed(quo_r) : $signed(quo_r))
              + 64'($signed({{48{mmin[15]}}, mmin}) + $signed({{48{offs[15]}}, offs})) * 1024;
  always_comb begin
    xsat = x_r;
    if (x_r > -64'sd656 && x_r < 64'sd656) xsat = '0;
    else if (x_r > 64'sd2147483647) xsat = 64'sd2147483647;
    else if (x_r < -64'sd2147483648) xsat = -64'sd2147483648;
  end
  assign sabs = sum_r[39] ? -sum_r : sum_r;

  always_comb begin
    ram_we = 1'b0;
    ram_wa = clr_r;
    ram_wd = '0;
    if (state_r == S_CLR) begin
      ram_we = 1'b1;
    end else if (state_r == S_WR) begin
      ram_we = 1'b1;
      ram_wa = AW'(int'(req_r.channel[CW-1:0]) * MAX_WINDOW + int'(wpos_r));
      ram_wd = xsat[31:0];
    end
    ram_ra = AW'(int'(req_r.channel[CW-1:0]) * MAX_WINDOW + int'(idx_r[PW-1:0]));
  end

  assign q_take = (state_r == S_IDLE) && q_valid && !o_full_r;
  assign out_empty = !o_full_r;
  assign out_shunt_count = o_raw_r;
  assign out_magnitude = o_mag_r;
  assign out_average = o_avg_r;
  assign out_span_error = o_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      o_full_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) pos_r[i] <= '0;
    end else begin
      if (out_pop && o_full_r) o_full_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (int'(clr_r) == DEPTH - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_take) begin
            req_r <= q_req;
            len_r <= eff_len;
            if (!q_req.valid_ch || int'(ch) >= CHANNELS) begin
              o_raw_r <= q_req.raw;
              o_mag_r <= '0;
              o_avg_r <= '0;
              o_err_r <= 1'b0;
              o_full_r <= 1'b1;
            end else begin
              wpos_r <= (WW'(pos_r[ch]) >= eff_len) ? '0 : pos_r[ch];
              state_r <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          dif_r <= $signed({19'd0, req_r.raw}) - $signed({24'd0, imin}) * CURRENT_DIV;
          mdif_r <= 32'($signed(mmax) - $signed(mmin)) * 1024;
          den_r <= {16'd0, dspan} * CURRENT_DIV;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          num_r <= 64'(dif_r) * 64'(mdif_r);
          it_r <= '0;
          rem_r <= '0;
          if (dspan == 16'd0) begin
            err_r <= 1'b1;
            x_r <= 64'(SPAN_ERR_VALUE);
            state_r <= S_WR;
          end else begin
            err_r <= 1'b0;
            state_r <= S_ABS;
          end
        end
        S_ABS: begin
          neg_r <= num_r[63];
          nabs_r <= num_r[63] ? -num_r : num_r;
          state_r <= S_DIV;
        end
        S_DIV: begin
          nabs_r <= {nabs_r[62:0], 1'b0};
          if (!trial[64]) begin
            rem_r <= trial[63:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], nabs_r[63]};
            quo_r <= {quo_r[62:0], 1'b0};
          end
          it_r <= it_r + 7'd1;
          if (it_r == 7'd63) state_r <= S_FIX;
        end
        S_FIX: begin
          x_r <= xadj;
          state_r <= S_WR;
        end
        S_WR: begin
          pos_r[req_r.channel[CW-1:0]] <= (WW'(wpos_r) + WW'(1) >= len_r) ? '0
                                          : PW'(wpos_r + PW'(1));
          idx_r <= '0;
          sum_r <= '0;
          state_r <= S_SUM;
        end
        S_SUM: begin
          idx_r <= idx_r + WW'(1);
          state_r <= S_SUMW;
        end
        S_SUMW: begin
          sum_r <= sum_r + 40'(signed'(ram_rd));
          if (idx_r == len_r) begin
            nabs_r <= '0;
            state_r <= S_AVG;
            it_r <= '0;
            rem_r <= '0;
          end else begin
            idx_r <= idx_r + WW'(1);
          end
        end
        S_AVG: begin
          if (it_r == 7'd0) begin
            neg_r <= sum_r[39];
            nabs_r <= {sabs, 24'd0};
            den_r <= 32'(len_r);
            it_r <= 7'd1;
          end else begin
            nabs_r <= {nabs_r[62:0], 1'b0};
            if (!trial[64]) begin
              rem_r <= trial[63:0];
              quo_r <= {quo_r[62:0], 1'b1};
            end else begin
              rem_r <= {rem_r[62:0], nabs_r[63]};
              quo_r <= {quo_r[62:0], 1'b0};
            end
            it_r <= it_r + 7'd1;
            if (it_r == 7'd40) state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!o_full_r) begin
            o_raw_r <= req_r.raw;
            o_mag_r <= xsat[31:0];
            o_avg_r <= neg_r ? -quo_r[31:0] : quo_r[31:0];
            o_err_r <= err_r;
            o_full_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> state_r == S_IDLE) else $error("take outside idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> den_r != '0) else $error("zero divisor");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUMW) |-> idx_r <= len_r) else $error("sum index overrun");

endmodule

// ----- rtl/core/current_loop_scale_average_top.sv -----
// After accept the back end multiplies, runs a 64-step quotient divider, writes the sample,
// then sums the L entries of the window (L = effective window length) and runs an averaging divider.
// Zero span skips the quotient divider; an invalid channel's result is registered at accept.
// The back end holds one request at a time and takes the next only when idle and its output register is empty.
// Reset (synchronous, rst_n low) loads calibration defaults and then clears all
// CHANNELS*MAX_WINDOW entries of the sample RAM, one entry a cycle; requests queue meanwhile.
module current_loop_scale_average_top import clsa_pkg::*; #(
  parameter int MAX_WINDOW = 16,
  parameter int CHANNELS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_channel,
  input  logic [15:0]        in_shunt_word,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [12:0]        out_shunt_count,
  output logic signed [31:0] out_magnitude,
  output logic signed [31:0] out_average,
  output logic               out_span_error
);

  logic [63:0] cal_r [CAL_REGS];
  logic [4:0]  win_r;
  logic        q_valid, q_take;
  clsa_req_t   q_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAL_REGS; i++) cal_r[i] <= CAL_RESET;
      win_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW) win_r <= cfg_data[4:0];
      else cal_r[cfg_index] <= cfg_data;
    end
  end

  clsa_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_channel, .in_shunt_word,
    .cal0(cal_r[0]), .cal1(cal_r[1]), .cal2(cal_r[2]),
    .q_valid, .q_req, .q_take
  );

  clsa_back #(.MAX_WINDOW(MAX_WINDOW), .CHANNELS(CHANNELS)) u_back (
    .clk, .rst_n, .window_len(win_r), .q_valid, .q_req, .q_take,
    .out_empty, .out_pop, .out_shunt_count, .out_magnitude, .out_average, .out_span_error
  );

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import clsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_MAX = 16;
  localparam int NUM_CH = 3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [1:0]  channel;
    logic [15:0] shunt_word;
  } sample_req_t;

  typedef struct packed {
    logic [12:0]        shunt_count;
    logic signed [31:0] magnitude;
    logic signed [31:0] average;
    logic               span_error;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [1:0]         in_channel = '0;
  logic [15:0]        in_shunt_word = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [12:0]        out_shunt_count;
  logic signed [31:0] out_magnitude;
  logic signed [31:0] out_average;
  logic               out_span_error;

  current_loop_scale_average_top u_dut (.*);

  always #5 clk = ~clk;

  sample_req_t pending_reqs[$];
  reading_t    readings_due[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;

  // scaler state
  logic [63:0] cal_word[NUM_CH];
  logic [4:0]  window_len;
  int          ring[NUM_CH][WINDOW_MAX];
  int          ring_pos[NUM_CH];

  function automatic reading_t scale_and_average(sample_req_t req);
    reading_t r;
    longint imin, imax, mmin, mmax, offs, span, x, sum;
    int len, pos;
    logic [63:0] c;
    r = '0;
    r.shunt_count = req.shunt_word[15:3];
    if (req.channel >= NUM_CH) return r;
    c = cal_word[req.channel];
    imin = c[7:0];
    imax = c[15:8];
    mmin = $signed(c[31:16]);
    mmax = $signed(c[47:32]);
    offs = $signed(c[63:48]);
    span = imax - imin;
    if (span < 0) span += 65536;
    if (span == 0) begin
      x = SPAN_ERR_VALUE;
      r.span_error = 1'b1;
    end else begin
      x = ((longint'(r.shunt_count) - CURRENT_DIV * imin) * 1024 * (mmax - mmin)) /
          (CURRENT_DIV * span);
      x += (mmin + offs) * 1024;
      if (x > -ZERO_BAND && x < ZERO_BAND) x = 0;
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
    end
    len = (window_len == 0) ? 1 : (window_len > WINDOW_MAX) ? WINDOW_MAX : window_len;
    pos = ring_pos[req.channel];
    if (pos >= len) pos = 0;
    ring[req.channel][pos] = int'(x);
    pos++;
    if (pos >= len) pos = 0;
    ring_pos[req.channel] = pos;
    sum = 0;
    for (int i = 0; i < len; i++) sum += ring[req.channel][i];
    sum = sum / len;
    r.magnitude = int'(x);
    r.average = int'(sum);
    return r;
  endfunction

  // driver: requests change on the falling edge
  always @(negedge clk) begin
    if (rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
      in_push <= 1'b1;
      in_channel <= pending_reqs[0].channel;
      in_shunt_word <= pending_reqs[0].shunt_word;
    end else begin
      in_push <= 1'b0;
    end
    out_pop <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // acceptance, prediction and checking
  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        cal_word[c] = CAL_RESET;
        ring_pos[c] = 0;
        for (int i = 0; i < WINDOW_MAX; i++) ring[c][i] = 0;
      end
      window_len = WINDOW_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WINDOW) window_len = cfg_data[4:0];
        else cal_word[cfg_index - REG_CAL0] = cfg_data;
      end
      idle_cycles++;
      if (in_push && !in_full) begin
        readings_due.push_back(scale_and_average(pending_reqs.pop_front()));
        idle_cycles = 0;
      end
      if (out_pop && !out_empty) begin
        idle_cycles = 0;
        if (readings_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected reading raw=%0d mag=%0d avg=%0d err=%0b", $time,
                   out_shunt_count, out_magnitude, out_average, out_span_error);
        end else begin
          exp_r = readings_due.pop_front();
          if (out_shunt_count !== exp_r.shunt_count || out_magnitude !== exp_r.magnitude ||
              out_average !== exp_r.average || out_span_error !== exp_r.span_error) begin
            errors++;
            $display("%0t: mismatch expected raw=%0d mag=%0d avg=%0d err=%0b", $time,
                     exp_r.shunt_count, exp_r.magnitude, exp_r.average, exp_r.span_error);
            $display("%0t:          actual   raw=%0d mag=%0d avg=%0d err=%0b", $time,
                     out_shunt_count, out_magnitude, out_average, out_span_error);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || readings_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] cal_pack(logic [7:0] imin, logic [7:0] imax,
      logic [15:0] mmin, logic [15:0] mmax, logic [15:0] offs);
    return {offs, mmax, mmin, imax, imin};
  endfunction

  task automatic queue_req(logic [1:0] ch, logic [15:0] word);
    sample_req_t q;
    q.channel = ch;
    q.shunt_word = word;
    pending_reqs.push_back(q);
  endtask

  task automatic queue_random(int n);
    logic [1:0] ch;
    logic [15:0] word;
    for (int i = 0; i < n; i++) begin
      ch = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(NUM_CH - 1));
      case ($urandom_range(3))
        0: word = 16'($urandom);
        1: word = 16'($urandom_range(3660, 732) << 3) | 16'($urandom_range(7));
        2: word = $urandom_range(1) ? 16'hFFFF - 16'($urandom_range(15)) : 16'($urandom_range(15));
        default: word = 16'($urandom_range(8191));
      endcase
      queue_req(ch, word);
    end
  endtask

  function automatic logic [63:0] random_cal();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return cal_pack(8'($urandom_range(4, 3)), 8'($urandom_range(20, 18)),
                         16'($signed(-$urandom_range(640))), 16'($urandom_range(6400)),
                         16'($signed($urandom_range(128) - 64)));
      2: return cal_pack(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      default: return cal_pack(8'($urandom_range(10)), 8'($urandom_range(30, 5)),
                               16'($urandom_range(1000)), 16'($urandom_range(20000)),
                               16'($signed($urandom_range(200) - 100)));
    endcase
  endfunction

  initial begin
    logic [4:0] win_set[6];
    int idle_set[4][2];
    win_set = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd10};
    idle_set = '{'{0, 0}, '{55, 0}, '{0, 55}, '{17, 17}};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults, field extremes, every channel, invalid channel
    queue_req(2'd0, 16'h0000);
    queue_req(2'd0, 16'hFFFF);
    queue_req(2'd1, 16'd7328);
    queue_req(2'd2, 16'd29280);
    queue_req(2'd3, 16'hFFFF);
    queue_req(2'd3, 16'h0000);
    queue_req(2'd2, 16'hAAAA);
    queue_req(2'd1, 16'h5555);
    wait_drained();

    // zero span, wrapped span, overflow both ways, near-zero result
    write_reg(REG_CAL0, cal_pack(8'd5, 8'd5, 16'd0, 16'd640, 16'd0));
    write_reg(REG_CAL0 + 2'd1, cal_pack(8'd20, 8'd4, 16'h8000, 16'h7FFF, 16'h7FFF));
    write_reg(REG_CAL0 + 2'd2, cal_pack(8'd0, 8'd1, 16'h7FFF, 16'h8000, 16'h8000));
    write_reg(REG_WINDOW, 5'd3);
    queue_req(2'd0, 16'h1234);
    queue_req(2'd0, 16'hFFFF);
    queue_req(2'd1, 16'h0000);
    queue_req(2'd1, 16'hFFFF);
    queue_req(2'd2, 16'hFFFF);
    queue_req(2'd2, 16'h0000);
    wait_drained();
    write_reg(REG_CAL0, cal_pack(8'd0, 8'd20, 16'd0, 16'd1, 16'd0));
    write_reg(REG_WINDOW, 5'd31);
    queue_req(2'd0, 16'd800);
    queue_req(2'd0, 16'd0);
    queue_req(2'd0, 16'hFFFF);
    wait_drained();
    // shrink below stale write positions
    write_reg(REG_WINDOW, 5'd2);
    queue_req(2'd0, 16'd4000);
    queue_req(2'd1, 16'd4000);
    queue_req(2'd2, 16'd4000);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      for (int c = 0; c < NUM_CH; c++) write_reg(REG_CAL0 + 2'(c), random_cal());
      write_reg(REG_WINDOW, (ph < 6) ? win_set[ph] : 5'($urandom));
      sender_idle_pct = idle_set[ph % 4][0];
      receiver_stall_pct = idle_set[ph % 4][1];
      queue_random(140);
      wait_drained();
    end

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
